### rtl/bba_pkg.sv
// Buddy allocator package: payload structs, register indexes, controller and
// datapath command/status types. No dependencies.
package bba_pkg;

   localparam int ADDR_W        = 48;
   localparam int LEN_W         = 41;
   localparam int PLOG_W        = 6;
   localparam int LEAF_W        = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 48;
   localparam logic [PLOG_W-1:0] POOL_LOG2_MAX = 6'd40;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAF = 2'd2;

   localparam logic [ADDR_W-1:0] BASE_RST = '0;
   localparam logic [PLOG_W-1:0] POOL_RST = 6'd20;
   localparam logic [LEAF_W-1:0] LEAF_RST = 4'd8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [LEN_W-1:0]  request_length;
      logic [ADDR_W-1:0] free_address;
   } bba_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] block_address;
   } bba_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_DEPTH,
      OP_READ,
      OP_READ_SIB,
      OP_S_CHILD,
      OP_S_NEXT_K,
      OP_SPLIT_NODE,
      OP_SPLIT_SIB,
      OP_MARK,
      OP_UP_ALLOC,
      OP_F_DOWN,
      OP_F_CLR,
      OP_UP_FREE,
      OP_FAIL,
      OP_ALLOC_OK,
      OP_FREE_OK
   } bba_op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DEPTH,
      ST_S_RD,
      ST_S_EV,
      ST_SPLIT_A,
      ST_SPLIT_B,
      ST_MARK,
      ST_U_RD,
      ST_U_WR,
      ST_F_RD,
      ST_F_EV,
      ST_FU_RD,
      ST_FU_WR,
      ST_FAIL,
      ST_AOK,
      ST_FOK
   } bba_state_type;

   typedef struct packed {
      bba_op_type op;
   } bba_cmd_type;

   typedef struct packed {
      logic is_free;
      logic clr_done;
      logic oversize;
      logic off_out;
      logic depth_more;
      logic q_split;
      logic q_full;
      logic t_eq_d;
      logic t1_eq_d;
      logic t_zero;
      logic t_one;
      logic pos_last;
      logic f_more;
   } bba_sts_type;

endpackage

### rtl/bba_dpath.sv
// Buddy allocator datapath: config registers, node flag memory, tree cursor
// and result register. Depends on bba_pkg; driven by bba_ctrl commands.
module bba_dpath #(
   parameter int MAX_DEPTH = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  bba_pkg::bba_req_type                 req_data,
   input  bba_pkg::bba_cmd_type                 cmd,
   output bba_pkg::bba_sts_type                 sts,
   output bba_pkg::bba_rsp_type                 rsp_data
);

   localparam int NODE_W   = MAX_DEPTH + 1;
   localparam int NODE_CNT = (1 << NODE_W) - 1;
   localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
   localparam int K_W      = MAX_DEPTH + 1;
   localparam logic [bba_pkg::PLOG_W-1:0] MAXD6 = bba_pkg::PLOG_W'(MAX_DEPTH);
   localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(NODE_CNT - 1);

   // bit 1 split, bit 0 full
   logic [1:0] mem [NODE_CNT];

   logic [bba_pkg::ADDR_W-1:0] base_ff;
   logic [bba_pkg::PLOG_W-1:0] plog_ff;
   logic [bba_pkg::LEAF_W-1:0] leaf_ff;
   logic [NODE_W-1:0]          clr_ff;

   logic                       cmd_ff;
   logic [bba_pkg::LEN_W-1:0]  len_ff;
   logic [bba_pkg::ADDR_W-1:0] off_ff;
   logic [bba_pkg::PLOG_W-1:0] p_ff;
   logic [DEPTH_W-1:0]         lf_ff;
   logic [DEPTH_W-1:0]         d_ff;
   logic [DEPTH_W-1:0]         t_ff;
   logic [K_W-1:0]             k_ff;
   logic [K_W-1:0]             fpos_ff;
   logic [1:0]                 cf_ff;
   logic [1:0]                 q_ff;
   bba_pkg::bba_rsp_type       rsp_ff;

   logic [bba_pkg::PLOG_W-1:0] p_in;
   logic [bba_pkg::PLOG_W-1:0] lf6_in;
   logic [bba_pkg::PLOG_W-1:0] t6;
   logic [bba_pkg::PLOG_W-1:0] d6;
   logic [K_W-1:0]             apos;
   logic [K_W-1:0]             cpos;
   logic [K_W-1:0]             pos;
   logic [K_W-1:0]             next_k;
   logic [NODE_W-1:0]          cur_idx;
   logic [NODE_W-1:0]          sib_idx;
   logic [NODE_W-1:0]          par_idx;
   logic [NODE_W-1:0]          csib_idx;
   logic                       fbit;
   logic                       mem_we;
   logic                       mem_re;
   logic [NODE_W-1:0]          waddr;
   logic [NODE_W-1:0]          raddr;
   logic [1:0]                 wdata;
   logic [bba_pkg::ADDR_W-1:0] alloc_addr;

   function automatic logic [NODE_W-1:0] idx_of(input logic [DEPTH_W-1:0] t,
                                                input logic [K_W-1:0] p);
      idx_of = (NODE_W'(1) << t) - NODE_W'(1) + NODE_W'(p);
   endfunction

   always_comb begin
      p_in = (plog_ff > bba_pkg::POOL_LOG2_MAX) ? bba_pkg::POOL_LOG2_MAX : plog_ff;
      lf6_in = bba_pkg::PLOG_W'(leaf_ff);
      if (lf6_in > MAXD6) lf6_in = MAXD6;
      if (lf6_in > p_in) lf6_in = p_in;
   end

   assign t6       = bba_pkg::PLOG_W'(t_ff);
   assign d6       = bba_pkg::PLOG_W'(d_ff);
   assign apos     = k_ff >> (d_ff - t_ff);
   assign cpos     = k_ff >> (d_ff - t_ff - DEPTH_W'(1));
   assign pos      = cmd_ff ? fpos_ff : apos;
   assign next_k   = (pos + K_W'(1)) << (d_ff - t_ff);
   assign cur_idx  = idx_of(t_ff, pos);
   assign sib_idx  = idx_of(t_ff, pos ^ K_W'(1));
   assign par_idx  = idx_of(t_ff - DEPTH_W'(1), pos >> 1);
   assign csib_idx = idx_of(t_ff + DEPTH_W'(1), cpos ^ K_W'(1));
   assign fbit     = off_ff[6'(p_ff - 6'd1 - t6)];
   assign alloc_addr = base_ff + (bba_pkg::ADDR_W'(k_ff) << (p_ff - d6));

   always_comb begin
      sts.is_free    = cmd_ff;
      sts.clr_done   = (clr_ff == LAST_IDX);
      sts.oversize   = len_ff > (bba_pkg::LEN_W'(1) << p_ff);
      sts.off_out    = off_ff >= (bba_pkg::ADDR_W'(1) << p_ff);
      sts.depth_more = (d_ff < lf_ff) &&
                       (len_ff <= (bba_pkg::LEN_W'(1) << (p_ff - d6 - 6'd1)));
      sts.q_split    = q_ff[1];
      sts.q_full     = q_ff[0];
      sts.t_eq_d     = (t_ff == d_ff);
      sts.t1_eq_d    = ((t_ff + DEPTH_W'(1)) == d_ff);
      sts.t_zero     = (t_ff == '0);
      sts.t_one      = (t_ff == DEPTH_W'(1));
      sts.pos_last   = (pos == ((K_W'(1) << t_ff) - K_W'(1)));
      sts.f_more     = (t6 < MAXD6) && (t6 < p_ff);
   end

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      waddr  = cur_idx;
      raddr  = cur_idx;
      wdata  = 2'b00;
      case (cmd.op)
         bba_pkg::OP_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_ff;
         end
         bba_pkg::OP_READ: begin
            mem_re = 1'b1;
         end
         bba_pkg::OP_READ_SIB: begin
            mem_re = 1'b1;
            raddr  = sib_idx;
         end
         bba_pkg::OP_SPLIT_NODE: begin
            mem_we = 1'b1;
            wdata  = 2'b10;
         end
         bba_pkg::OP_SPLIT_SIB: begin
            mem_we = 1'b1;
            waddr  = csib_idx;
         end
         bba_pkg::OP_MARK: begin
            mem_we = 1'b1;
            wdata  = 2'b01;
         end
         bba_pkg::OP_UP_ALLOC: begin
            mem_we = 1'b1;
            waddr  = par_idx;
            wdata  = {1'b1, cf_ff[0] & q_ff[0]};
         end
         bba_pkg::OP_F_CLR: begin
            mem_we = 1'b1;
            wdata  = {q_ff[1], 1'b0};
         end
         bba_pkg::OP_UP_FREE: begin
            mem_we = 1'b1;
            waddr  = par_idx;
            wdata  = {(|cf_ff) | (|q_ff), 1'b0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) q_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= bba_pkg::BASE_RST;
         plog_ff <= bba_pkg::POOL_RST;
         leaf_ff <= bba_pkg::LEAF_RST;
      end else if (csr_we) begin
         case (csr_index)
            bba_pkg::CSR_BASE: base_ff <= csr_wdata[bba_pkg::ADDR_W-1:0];
            bba_pkg::CSR_POOL: plog_ff <= csr_wdata[bba_pkg::PLOG_W-1:0];
            bba_pkg::CSR_LEAF: leaf_ff <= csr_wdata[bba_pkg::LEAF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.op == bba_pkg::OP_CLEAR && clr_ff != LAST_IDX) clr_ff <= clr_ff + NODE_W'(1);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         bba_pkg::OP_LOAD: begin
            cmd_ff  <= req_data.cmd;
            len_ff  <= req_data.request_length;
            off_ff  <= req_data.free_address - base_ff;
            p_ff    <= p_in;
            lf_ff   <= DEPTH_W'(lf6_in);
            d_ff    <= '0;
            t_ff    <= '0;
            k_ff    <= '0;
            fpos_ff <= '0;
         end
         bba_pkg::OP_DEPTH:    d_ff <= d_ff + DEPTH_W'(1);
         bba_pkg::OP_S_CHILD:  t_ff <= t_ff + DEPTH_W'(1);
         bba_pkg::OP_S_NEXT_K: begin
            k_ff <= next_k;
            t_ff <= '0;
         end
         bba_pkg::OP_SPLIT_SIB: t_ff <= t_ff + DEPTH_W'(1);
         bba_pkg::OP_MARK:      cf_ff <= 2'b01;
         bba_pkg::OP_UP_ALLOC: begin
            cf_ff <= {1'b1, cf_ff[0] & q_ff[0]};
            t_ff  <= t_ff - DEPTH_W'(1);
         end
         bba_pkg::OP_F_DOWN: begin
            fpos_ff <= {fpos_ff[K_W-2:0], fbit};
            t_ff    <= t_ff + DEPTH_W'(1);
         end
         bba_pkg::OP_F_CLR: cf_ff <= {q_ff[1], 1'b0};
         bba_pkg::OP_UP_FREE: begin
            cf_ff   <= {(|cf_ff) | (|q_ff), 1'b0};
            fpos_ff <= fpos_ff >> 1;
            t_ff    <= t_ff - DEPTH_W'(1);
         end
         bba_pkg::OP_FAIL: begin
            rsp_ff.ok            <= 1'b0;
            rsp_ff.block_address <= '0;
         end
         bba_pkg::OP_ALLOC_OK: begin
            rsp_ff.ok            <= 1'b1;
            rsp_ff.block_address <= alloc_addr;
         end
         bba_pkg::OP_FREE_OK: begin
            rsp_ff.ok            <= 1'b1;
            rsp_ff.block_address <= '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/bba_ctrl.sv
// Buddy allocator controller: sequences clear pass, search, split, mark and
// merge steps. Depends on bba_pkg; drives bba_dpath through bba_cmd_type.
module bba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bba_pkg::bba_sts_type sts,
   output bba_pkg::bba_cmd_type cmd
);

   bba_pkg::bba_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = bba_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            cmd.op = bba_pkg::OP_CLEAR;
            if (sts.clr_done) state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = bba_pkg::OP_LOAD;
               state_in = bba_pkg::ST_CHECK;
            end
         end
         bba_pkg::ST_CHECK: begin
            if (sts.is_free) state_in = sts.off_out ? bba_pkg::ST_FAIL : bba_pkg::ST_F_RD;
            else state_in = sts.oversize ? bba_pkg::ST_FAIL : bba_pkg::ST_DEPTH;
         end
         bba_pkg::ST_DEPTH: begin
            if (sts.depth_more) cmd.op = bba_pkg::OP_DEPTH;
            else state_in = bba_pkg::ST_S_RD;
         end
         bba_pkg::ST_S_RD: begin
            cmd.op   = bba_pkg::OP_READ;
            state_in = bba_pkg::ST_S_EV;
         end
         bba_pkg::ST_S_EV: begin
            if (!sts.q_full && !sts.q_split) begin
               state_in = sts.t_eq_d ? bba_pkg::ST_MARK : bba_pkg::ST_SPLIT_A;
            end else if (sts.q_full || sts.t_eq_d) begin
               if (sts.pos_last) state_in = bba_pkg::ST_FAIL;
               else begin
                  cmd.op   = bba_pkg::OP_S_NEXT_K;
                  state_in = bba_pkg::ST_S_RD;
               end
            end else begin
               cmd.op   = bba_pkg::OP_S_CHILD;
               state_in = bba_pkg::ST_S_RD;
            end
         end
         bba_pkg::ST_SPLIT_A: begin
            cmd.op   = bba_pkg::OP_SPLIT_NODE;
            state_in = bba_pkg::ST_SPLIT_B;
         end
         bba_pkg::ST_SPLIT_B: begin
            cmd.op   = bba_pkg::OP_SPLIT_SIB;
            state_in = sts.t1_eq_d ? bba_pkg::ST_MARK : bba_pkg::ST_SPLIT_A;
         end
         bba_pkg::ST_MARK: begin
            cmd.op   = bba_pkg::OP_MARK;
            state_in = sts.t_zero ? bba_pkg::ST_AOK : bba_pkg::ST_U_RD;
         end
         bba_pkg::ST_U_RD: begin
            cmd.op   = bba_pkg::OP_READ_SIB;
            state_in = bba_pkg::ST_U_WR;
         end
         bba_pkg::ST_U_WR: begin
            cmd.op   = bba_pkg::OP_UP_ALLOC;
            state_in = sts.t_one ? bba_pkg::ST_AOK : bba_pkg::ST_U_RD;
         end
         bba_pkg::ST_F_RD: begin
            cmd.op   = bba_pkg::OP_READ;
            state_in = bba_pkg::ST_F_EV;
         end
         bba_pkg::ST_F_EV: begin
            if (sts.q_split && sts.f_more) begin
               cmd.op   = bba_pkg::OP_F_DOWN;
               state_in = bba_pkg::ST_F_RD;
            end else if (!sts.q_full) begin
               state_in = bba_pkg::ST_FAIL;
            end else begin
               cmd.op   = bba_pkg::OP_F_CLR;
               state_in = sts.t_zero ? bba_pkg::ST_FOK : bba_pkg::ST_FU_RD;
            end
         end
         bba_pkg::ST_FU_RD: begin
            cmd.op   = bba_pkg::OP_READ_SIB;
            state_in = bba_pkg::ST_FU_WR;
         end
         bba_pkg::ST_FU_WR: begin
            cmd.op   = bba_pkg::OP_UP_FREE;
            state_in = sts.t_one ? bba_pkg::ST_FOK : bba_pkg::ST_FU_RD;
         end
         bba_pkg::ST_FAIL, bba_pkg::ST_AOK, bba_pkg::ST_FOK: begin
            if (slot_free) begin
               case (state_ff)
                  bba_pkg::ST_FAIL: cmd.op = bba_pkg::OP_FAIL;
                  bba_pkg::ST_AOK:  cmd.op = bba_pkg::OP_ALLOC_OK;
                  default:          cmd.op = bba_pkg::OP_FREE_OK;
               endcase
               rsp_valid_in = 1'b1;
               state_in     = bba_pkg::ST_IDLE;
            end
         end
         default: state_in = bba_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != bba_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // result register is never overwritten while a stalled transfer waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bba_pkg::OP_FAIL || cmd.op == bba_pkg::OP_ALLOC_OK ||
       cmd.op == bba_pkg::OP_FREE_OK) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == bba_pkg::ST_CHECK))
      else $error("accepted request not checked");

   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_U_WR || state_ff == bba_pkg::ST_FU_WR) |-> !sts.t_zero)
      else $error("parent update at root");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_CHECK) |-> !$past(rsp_valid_in && !rsp_valid_ff))
      else $error("result issued during load");

endmodule

### rtl/binary_buddy_allocator_core.sv
// Binary buddy allocator top level: ties controller and datapath together.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// Usage: requests arrive on req_* (valid/stall), one result per request leaves
// on rsp_* (valid/stall). cmd 0 allocates request_length bytes and returns the
// block start; cmd 1 frees the block holding free_address. Registers are set
// through csr_we/csr_index/csr_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce.
// One request is in work at a time. Every tree node visit is a registered read
// of the one-port flag memory, then an evaluate/write step. The search restarts
// at the root after each full or split-at-target node, which sets the worst
// case. After reset the flag memory is cleared one node a cycle, all
// 2^(MAX_DEPTH+1)-1 nodes (2047 by default), with req_stall high; config
// writes are taken throughout. A finished result sits in the output register
// while rsp_stall is high and the next request is accepted meanwhile; its
// result waits until the register drains.
module binary_buddy_allocator_core #(
   parameter int MAX_DEPTH = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bba_pkg::bba_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bba_pkg::bba_rsp_type           rsp_data
);

   bba_pkg::bba_cmd_type cmd;
   bba_pkg::bba_sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_dpath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

### test/bba_checker.sv
`timescale 1ns / 100ps
// Buddy allocator checker: watches the csr, req and rsp ports, keeps its own
// split/full tree and compares every rsp transfer in order. Depends on bba_pkg.
module bba_checker #(
   parameter int MAX_DEPTH = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  bba_pkg::bba_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  bba_pkg::bba_rsp_type           rsp_data,
   output int                             errors,
   output int                             pending
);

   localparam int NODES = (1 << (MAX_DEPTH + 1)) - 1;

   bit                         split_f[NODES];
   bit                         full_f[NODES];
   logic [bba_pkg::ADDR_W-1:0] base_r;
   logic [bba_pkg::PLOG_W-1:0] plog_r;
   logic [bba_pkg::LEAF_W-1:0] leaf_r;
   bba_pkg::bba_rsp_type       grant_q[$];

   function automatic int pool_log2();
      return (plog_r > bba_pkg::POOL_LOG2_MAX) ? 40 : int'(plog_r);
   endfunction

   function automatic int leaf_eff();
      int d;
      d = int'(leaf_r);
      if (d > MAX_DEPTH) d = MAX_DEPTH;
      if (d > pool_log2()) d = pool_log2();
      return d;
   endfunction

   function automatic int node_of(int depth, int pos);
      return (1 << depth) - 1 + pos;
   endfunction

   function automatic bba_pkg::bba_rsp_type grant_alloc(logic [bba_pkg::LEN_W-1:0] len);
      int                   p, leaf, d, t, k, n, idx;
      longint unsigned      pool, l64, a;
      bit                   found;
      bba_pkg::bba_rsp_type r;
      r     = '0;
      p     = pool_log2();
      leaf  = leaf_eff();
      pool  = 64'd1 << p;
      l64   = len;
      d     = 0;
      found = 0;
      if (l64 > pool) return r;
      while (d < leaf && l64 <= (pool >> (d + 1))) d++;
      n = 1 << d;
      for (k = 0; k < n; k++) begin
         for (t = 0; t <= d; t++) begin
            idx = node_of(t, k >> (d - t));
            if (full_f[idx]) break;
            if (!split_f[idx]) begin
               found = 1;
               break;
            end
            if (t == d) break;
         end
         if (found) break;
      end
      if (!found) return r;
      for (t = 0; t < d; t++) begin
         idx = node_of(t, k >> (d - t));
         if (!split_f[idx]) begin
            split_f[idx] = 1;
            split_f[2*idx+1] = 0; full_f[2*idx+1] = 0;
            split_f[2*idx+2] = 0; full_f[2*idx+2] = 0;
         end
      end
      full_f[node_of(d, k)] = 1;
      for (t = d; t > 0; t--) begin
         idx = node_of(t - 1, k >> (d - t + 1));
         full_f[idx] = full_f[2*idx+1] && full_f[2*idx+2];
      end
      a = longint'(base_r) + (longint'(k) << (p - d));
      r.ok = 1'b1;
      r.block_address = a[bba_pkg::ADDR_W-1:0];
      return r;
   endfunction

   function automatic bba_pkg::bba_rsp_type release_block(logic [bba_pkg::ADDR_W-1:0] addr);
      logic [bba_pkg::ADDR_W-1:0] off;
      int                         p, idx, par, t;
      bba_pkg::bba_rsp_type       r;
      r   = '0;
      p   = pool_log2();
      off = addr - base_r;
      if ({16'b0, off} >= (64'd1 << p)) return r;
      idx = 0;
      t   = 0;
      while (split_f[idx] && t < MAX_DEPTH && t < p) begin
         idx = off[p-1-t] ? 2*idx + 2 : 2*idx + 1;
         t++;
      end
      if (!full_f[idx]) return r;
      full_f[idx] = 0;
      while (idx > 0) begin
         par = (idx - 1) / 2;
         full_f[par] = 0;
         if (!full_f[2*par+1] && !full_f[2*par+2] && !split_f[2*par+1] && !split_f[2*par+2])
            split_f[par] = 0;
         idx = par;
      end
      r.ok = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      bba_pkg::bba_rsp_type want;
      int                   i;
      if (reset) begin
         for (i = 0; i < NODES; i++) begin
            split_f[i] = 0;
            full_f[i]  = 0;
         end
         base_r = bba_pkg::BASE_RST;
         plog_r = bba_pkg::POOL_RST;
         leaf_r = bba_pkg::LEAF_RST;
         errors = 0;
         grant_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bba_pkg::CSR_BASE: base_r = csr_wdata;
               bba_pkg::CSR_POOL: plog_r = csr_wdata[bba_pkg::PLOG_W-1:0];
               bba_pkg::CSR_LEAF: leaf_r = csr_wdata[bba_pkg::LEAF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_data.cmd == bba_pkg::CMD_FREE)
               grant_q.push_back(release_block(req_data.free_address));
            else grant_q.push_back(grant_alloc(req_data.request_length));
         end
         if (rsp_valid && !rsp_stall) begin
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected rsp transfer ok=%0d addr=%h", $time, rsp_data.ok,
                        rsp_data.block_address);
               errors++;
            end else begin
               want = grant_q.pop_front();
               if (rsp_data.ok !== want.ok) begin
                  $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp_data.ok);
                  errors++;
               end
               if (rsp_data.block_address !== want.block_address) begin
                  $display("%0t: block_address expected %h actual %h", $time,
                           want.block_address, rsp_data.block_address);
                  errors++;
               end
            end
         end
      end
      pending = grant_q.size();
   end

endmodule

### test/tb_binary_buddy_allocator_core.sv
`timescale 1ns / 100ps
// Testbench top for binary_buddy_allocator_core: clock, reset, register
// phases and alloc/free stimulus. Depends on bba_pkg, binary_buddy_allocator_core and bba_checker.
module tb_binary_buddy_allocator_core;

   localparam int IDLE_LIMIT = 200000;
   localparam int PHASES     = 9;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [bba_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                           req_valid;
   logic                           req_stall;
   bba_pkg::bba_req_type           req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   bba_pkg::bba_rsp_type           rsp_data;
   int                             errors;
   int                             pending;

   logic [bba_pkg::ADDR_W-1:0] cur_base;
   int                         cur_p;
   int                         cur_leaf;
   int                         quiet;
   logic [bba_pkg::ADDR_W-1:0] held_q[$];
   logic                       cmd_q[$];
   int                         idle_cycles;

   binary_buddy_allocator_core i_dut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data
   );

   bba_checker i_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .errors, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   // track granted blocks so most frees hit something held
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) cmd_q.push_back(req_data.cmd);
         if (rsp_valid && !rsp_stall && cmd_q.size() > 0) begin
            if (cmd_q.pop_front() == bba_pkg::CMD_ALLOC && rsp_data.ok)
               held_q.push_back(rsp_data.block_address);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic v;
      int   n;
      rsp_stall = 1'b0;
      forever begin
         v = ($urandom_range(0, 2) == 0);
         n = idle_len() + 1;
         repeat (n) begin
            rsp_stall <= v;
            @(posedge clock);
         end
      end
   end

   function automatic bba_pkg::bba_req_type mk(logic c, logic [63:0] len, logic [63:0] a);
      bba_pkg::bba_req_type r;
      r.cmd            = c;
      r.request_length = len[bba_pkg::LEN_W-1:0];
      r.free_address   = a[bba_pkg::ADDR_W-1:0];
      return r;
   endfunction

   function automatic bba_pkg::bba_req_type make_item();
      bba_pkg::bba_req_type r;
      logic [63:0]          pool, lo, hi, w;
      int                   c, d, j;
      w = rand64();
      r = mk(bba_pkg::CMD_ALLOC, rand64(), rand64());
      pool = 64'd1 << cur_p;
      c = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 52) begin
         if (c < 4) r.request_length = '0;
         else if (c < 9) begin
            w = pool + 1 + ($urandom % 4096);
            r.request_length = w[bba_pkg::LEN_W-1:0];
         end else if (c >= 13) begin
            d  = $urandom_range(0, cur_leaf);
            hi = pool >> d;
            lo = (d == cur_leaf) ? 64'd0 : pool >> (d + 1);
            w  = lo + 1 + (rand64() % (hi - lo));
            r.request_length = w[bba_pkg::LEN_W-1:0];
         end
      end else begin
         r.cmd = bba_pkg::CMD_FREE;
         if (c < 70 && held_q.size() > 0) begin
            j = $urandom_range(0, held_q.size() - 1);
            w = {16'b0, held_q[j]} + (rand64() % (pool >> cur_leaf));
            r.free_address = w[bba_pkg::ADDR_W-1:0];
            held_q.delete(j);
         end else if (c < 85) begin
            w = {16'b0, cur_base} + (rand64() % pool);
            r.free_address = w[bba_pkg::ADDR_W-1:0];
         end else if (c < 93) begin
            w = {16'b0, cur_base} + pool + ($urandom % 256);
            r.free_address = w[bba_pkg::ADDR_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic send(input bba_pkg::bba_req_type item);
      int gap;
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [bba_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[bba_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic configure(input logic [bba_pkg::ADDR_W-1:0] b, input int plog, input int leaf);
      logic [63:0] w;
      write_reg(bba_pkg::CSR_BASE, {16'b0, b});
      w = rand64();
      w[bba_pkg::PLOG_W-1:0] = bba_pkg::PLOG_W'(plog);
      write_reg(bba_pkg::CSR_POOL, w);
      w = rand64();
      w[bba_pkg::LEAF_W-1:0] = bba_pkg::LEAF_W'(leaf);
      write_reg(bba_pkg::CSR_LEAF, w);
      csr_we   <= 1'b0;
      cur_base = b;
      cur_p    = (plog > 40) ? 40 : plog;
      cur_leaf = (leaf > 10) ? 10 : leaf;
      if (cur_leaf > cur_p) cur_leaf = cur_p;
      held_q.delete();
   endtask

   initial begin
      logic [bba_pkg::ADDR_W-1:0] ph_base[PHASES];
      int                         ph_plog[PHASES];
      int                         ph_leaf[PHASES];
      int                         ph_n[PHASES];
      int                         ph, i;
      ph_base = '{48'h0, 48'hFFFF_FFFF_FF00, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0,
                  48'hFFFF_FFFF_FFFF};
      for (i = 2; i < 8; i++) ph_base[i] = bba_pkg::ADDR_W'(rand64());
      ph_plog = '{20, 10, 40, 0, 63, 5, 16, 33, 12};
      ph_leaf = '{8, 3, 10, 0, 15, 9, 4, 6, 2};
      ph_n    = '{150, 150, 60, 40, 60, 100, 200, 150, 140};
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data  = '0;
      quiet     = 0;
      cur_base  = bba_pkg::BASE_RST;
      cur_p     = 20;
      cur_leaf  = 8;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: edges of length, misses and frees outside the pool
      send(mk(bba_pkg::CMD_ALLOC, 0, '1));
      send(mk(bba_pkg::CMD_ALLOC, 1, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'd4096, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'd4097, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'd1 << 19, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'd1 << 20, 0));
      send(mk(bba_pkg::CMD_ALLOC, (64'd1 << 20) + 1, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'h1FF_FFFF_FFFF, 0));
      send(mk(bba_pkg::CMD_ALLOC, 64'd1 << 40, 0));
      send(mk(bba_pkg::CMD_FREE, '1, 0));
      send(mk(bba_pkg::CMD_FREE, 0, 0));
      send(mk(bba_pkg::CMD_FREE, 0, 64'd4096 + 5));
      send(mk(bba_pkg::CMD_FREE, 0, 64'd1 << 20));
      send(mk(bba_pkg::CMD_FREE, 0, 64'hFFFF_FFFF_FFFF));
      send(mk(bba_pkg::CMD_FREE, 0, (64'd1 << 19) + 7));
      send(mk(bba_pkg::CMD_FREE, 0, 64'd8192));
      send(mk(bba_pkg::CMD_ALLOC, 64'd1 << 20, 0));
      send(mk(bba_pkg::CMD_FREE, 0, 64'd100));
      send(mk(bba_pkg::CMD_ALLOC, 64'd3000, 0));

      for (ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
         configure(ph_base[ph], ph_plog[ph], ph_leaf[ph]);
         for (i = 0; i < ph_n[ph]; i++) begin
            if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            send(make_item());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
